FILE: rtl/lpcp_pkg.sv
// Shared types and constants of the length-prefixed command parser.
`default_nettype none
package lpcp_pkg;

  localparam int unsigned LIM_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = LIM_W;
  localparam int unsigned ACC_W      = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_RID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_KEY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_VALUE = 2'd2;

  localparam logic [LIM_W-1:0] RST_MAX_RID   = LIM_W'(4 * 1024);
  localparam logic [LIM_W-1:0] RST_MAX_KEY   = LIM_W'(1024);
  localparam logic [LIM_W-1:0] RST_MAX_VALUE = LIM_W'(1024 * 1024);

  localparam logic [7:0] VERSION_BYTE = 8'd1;
  localparam logic [7:0] OP_PUT       = 8'd1;
  localparam logic [7:0] OP_DELETE    = 8'd2;

  localparam logic [1:0] TAG_RID   = 2'd0;
  localparam logic [1:0] TAG_KEY   = 2'd1;
  localparam logic [1:0] TAG_VALUE = 2'd2;

  typedef enum logic [3:0] {
    PH_VERSION = 4'd0,
    PH_OP      = 4'd1,
    PH_LEN0    = 4'd2,
    PH_PAY0    = 4'd3,
    PH_LEN1    = 4'd4,
    PH_PAY1    = 4'd5,
    PH_LEN2    = 4'd6,
    PH_PAY2    = 4'd7,
    PH_TAIL    = 4'd8,
    PH_ABSORB  = 4'd9
  } phase_e;

  typedef enum logic [3:0] {
    ERR_NONE      = 4'd0,
    ERR_SHORT     = 4'd1,
    ERR_VERSION   = 4'd2,
    ERR_OP        = 4'd3,
    ERR_LEN_CUT   = 4'd4,
    ERR_RID_LIM   = 4'd5,
    ERR_KEY_LIM   = 4'd6,
    ERR_VALUE_LIM = 4'd7,
    ERR_PAY_CUT   = 4'd8,
    ERR_TRAILING  = 4'd9
  } err_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       payload_valid;
    logic [1:0] field_tag;
    logic       message_done;
    logic       message_ok;
    logic       is_delete;
    logic [3:0] error_code;
  } out_word_t;

  typedef struct packed {
    logic [LIM_W-1:0] max_request_id_len;
    logic [LIM_W-1:0] max_key_len;
    logic [LIM_W-1:0] max_value_len;
  } limits_t;

endpackage
`default_nettype wire

FILE: rtl/lpcp_stream_if.sv
// Valid/ready word channel carrying one payload struct.
`default_nettype none
interface lpcp_stream_if #(
  parameter type word_t = logic [7:0]
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

FILE: rtl/lpcp_cfg.sv
// Length limit registers with their write decoder.
`default_nettype none
module lpcp_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lpcp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output lpcp_pkg::limits_t                     limits_o
);
  import lpcp_pkg::*;

  limits_t lim_q, lim_d;

  always_comb begin
    lim_d = lim_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_RID:   lim_d.max_request_id_len = cfg_data_i;
        CFG_MAX_KEY:   lim_d.max_key_len        = cfg_data_i;
        CFG_MAX_VALUE: lim_d.max_value_len      = cfg_data_i;
        default:       lim_d = lim_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.max_request_id_len <= RST_MAX_RID;
      lim_q.max_key_len        <= RST_MAX_KEY;
      lim_q.max_value_len      <= RST_MAX_VALUE;
    end else begin
      lim_q <= lim_d;
    end
  end

  assign limits_o = lim_q;

endmodule
`default_nettype wire

FILE: rtl/lpcp_parse.sv
// Parse state machine: checks one word per step and builds its result word.
`default_nettype none
module lpcp_parse #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire lpcp_pkg::in_word_t  word_i,
  input  wire lpcp_pkg::limits_t   limits_i,
  output lpcp_pkg::out_word_t      result_o
);
  import lpcp_pkg::*;

  localparam int unsigned CNT_W = (LENGTH_BYTES > 1) ? $clog2(LENGTH_BYTES) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LENGTH_BYTES - 1);

  phase_e           phase_q, phase_d;
  logic [ACC_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [ACC_W-1:0] rem_q, rem_d;
  err_e             err_q, err_d;
  logic             del_q, del_d;

  logic [ACC_W-1:0] acc_nx;
  logic [ACC_W-1:0] rem_nx;
  logic [3:0]       ph_off;
  logic [1:0]       fld;
  logic [LIM_W-1:0] lim;
  err_e             end_code;
  err_e             verdict;
  logic [7:0]       b;
  logic             eom;

  assign b   = word_i.in_byte;
  assign eom = word_i.end_of_message;

  // field index from a length or payload phase
  assign ph_off = phase_q - 4'(PH_LEN0);
  assign fld    = ph_off[2:1];

  always_comb begin
    case (fld)
      TAG_RID: lim = limits_i.max_request_id_len;
      TAG_KEY: lim = limits_i.max_key_len;
      default: lim = limits_i.max_value_len;
    endcase
  end

  // saturate once the top byte is occupied
  assign acc_nx = (acc_q[ACC_W-1:ACC_W-8] != 8'd0) ? '1 : {acc_q[ACC_W-9:0], b};
  assign rem_nx = (rem_q != '0) ? rem_q - ACC_W'(1) : rem_q;

  always_comb begin
    phase_d  = phase_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    rem_d    = rem_q;
    err_d    = err_q;
    del_d    = del_q;
    end_code = ERR_NONE;
    result_o = '0;

    unique case (phase_q)
      PH_VERSION: begin
        end_code = ERR_SHORT;
        if (!eom) begin
          if (b != VERSION_BYTE) begin
            err_d   = ERR_VERSION;
            phase_d = PH_ABSORB;
          end else begin
            phase_d = PH_OP;
          end
        end
      end
      PH_OP: begin
        if (b == OP_PUT || b == OP_DELETE) begin
          del_d    = (b == OP_DELETE);
          phase_d  = PH_LEN0;
          acc_d    = '0;
          cnt_d    = '0;
          end_code = ERR_LEN_CUT;
        end else begin
          err_d   = ERR_OP;
          phase_d = PH_ABSORB;
        end
      end
      PH_LEN0, PH_LEN1, PH_LEN2: begin
        acc_d = acc_nx;
        if (cnt_q != CNT_LAST) begin
          cnt_d    = cnt_q + CNT_W'(1);
          end_code = ERR_LEN_CUT;
        end else if (acc_nx > {{(ACC_W-LIM_W){1'b0}}, lim}) begin
          err_d   = err_e'(4'(ERR_RID_LIM) + {2'b00, fld});
          phase_d = PH_ABSORB;
        end else if (acc_nx == '0) begin
          if (fld != TAG_VALUE) begin
            phase_d  = phase_e'(phase_q + 4'd2);
            acc_d    = '0;
            cnt_d    = '0;
            end_code = ERR_LEN_CUT;
          end else begin
            phase_d = PH_TAIL;
          end
        end else begin
          rem_d    = acc_nx;
          phase_d  = phase_e'(phase_q + 4'd1);
          end_code = ERR_PAY_CUT;
        end
      end
      PH_PAY0, PH_PAY1, PH_PAY2: begin
        result_o.payload_valid = 1'b1;
        result_o.field_tag     = fld;
        result_o.out_byte      = b;
        rem_d                  = rem_nx;
        if (rem_nx == '0) begin
          if (fld != TAG_VALUE) begin
            phase_d  = phase_e'(phase_q + 4'd1);
            acc_d    = '0;
            cnt_d    = '0;
            end_code = ERR_LEN_CUT;
          end else begin
            phase_d = PH_TAIL;
          end
        end else begin
          end_code = ERR_PAY_CUT;
        end
      end
      PH_TAIL: begin
        if (err_q == ERR_NONE) begin
          err_d = ERR_TRAILING;
        end
        phase_d = PH_ABSORB;
      end
      default: begin
        phase_d = PH_ABSORB;
      end
    endcase

    verdict            = (err_d != ERR_NONE) ? err_d : end_code;
    result_o.is_delete    = del_d;
    result_o.message_done = eom;
    if (eom) begin
      result_o.message_ok = (verdict == ERR_NONE);
      result_o.error_code = verdict;
      phase_d = PH_VERSION;
      acc_d   = '0;
      cnt_d   = '0;
      rem_d   = '0;
      err_d   = ERR_NONE;
      del_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_VERSION;
      acc_q   <= '0;
      cnt_q   <= '0;
      rem_q   <= '0;
      err_q   <= ERR_NONE;
      del_q   <= 1'b0;
    end else if (step_i) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      cnt_q   <= cnt_d;
      rem_q   <= rem_d;
      err_q   <= err_d;
      del_q   <= del_d;
    end
  end

  // a payload phase always has bytes left to take
  a_pay_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY0 || phase_q == PH_PAY1 || phase_q == PH_PAY2) |-> rem_q != '0)
    else $error("payload phase with nothing remaining");

  // a latched error always parks the parser in absorb
  a_err_absorb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q != ERR_NONE) |-> phase_q == PH_ABSORB)
    else $error("error latched outside absorb");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_LAST)
    else $error("length byte count out of range");

  // an end mark always returns the parser to a clean start
  a_eom_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && eom) |=> (phase_q == PH_VERSION && err_q == ERR_NONE && !del_q))
    else $error("state not cleared after end of message");

endmodule
`default_nettype wire

FILE: rtl/length_prefixed_command_parser_core.sv
// Top level: input register, parse step, result register and limit registers.
// Path: an accepted word waits in the input register until the output register can
//   advance; then it is parsed and its result word is loaded into the output register.
// Throughput: one word per cycle while the output side is ready; the parse state and
//   result register advance together, so back-to-back words flow without bubbles.
// Reset: parser returns to expecting the version byte; limits reset to
//   4096 (request id), 1024 (key) and 1048576 (value) bytes.
`default_nettype none
module length_prefixed_command_parser_core #(
  parameter int unsigned LENGTH_BYTES = 4
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  lpcp_stream_if.sink                           in_i,
  lpcp_stream_if.source                         out_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [lpcp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [lpcp_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import lpcp_pkg::*;

  logic      in_v_q;
  in_word_t  in_q;
  logic      out_v_q;
  out_word_t out_q;
  out_word_t result;
  limits_t   limits;
  logic      advance;
  logic      step;

  assign advance  = !out_v_q || out_o.ready;
  assign step     = in_v_q && advance;
  assign in_i.ready = !in_v_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_i.ready) begin
      in_v_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_q <= in_i.data;
    end
  end

  lpcp_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .limits_o   (limits)
  );

  lpcp_parse #(
    .LENGTH_BYTES (LENGTH_BYTES)
  ) u_parse (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_q),
    .limits_i (limits),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (advance) begin
      out_v_q <= in_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_v_q;
  assign out_o.data  = out_q;

endmodule
`default_nettype wire

FILE: tb/sv/testbench.sv
// Self-checking testbench of the length-prefixed command parser core.
`timescale 1ns / 100ps

module testbench;
  import lpcp_pkg::*;

  localparam int LEN_BYTES = 4;
  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES = 8;
  localparam int PHASE_WORDS = 190;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum int {
    CMD_GOOD, CMD_CUT, CMD_TRAIL, CMD_BAD_VER, CMD_BAD_OP, CMD_OVER, CMD_NOISE
  } cmd_kind_e;

  typedef struct {
    in_word_t  w;
    bit        fixed;
    out_word_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpcp_stream_if #(.word_t(in_word_t)) in_ch ();
  lpcp_stream_if #(.word_t(out_word_t)) out_ch ();

  length_prefixed_command_parser_core #(.LENGTH_BYTES(LEN_BYTES)) u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  always #1 clk = ~clk;

  // parser image
  limits_t     lim;
  phase_e      pr_phase;
  logic [31:0] pr_len;
  int unsigned pr_cnt;
  logic [31:0] pr_left;
  err_e        pr_err;
  logic        pr_del;

  out_word_t  parsed_q[$];
  logic [7:0] cmd_bytes[$];
  dir_row_t   dir_rows[$];
  int         err_count = 0;
  int         items_sent = 0;
  int         cycles = 0;
  int         rx_hold = 0;
  bit         tx_calm = 1'b0;
  bit         rx_calm = 1'b0;

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_parse();
    pr_phase = PH_VERSION;
    pr_len = '0;
    pr_cnt = 0;
    pr_left = '0;
    pr_err = ERR_NONE;
    pr_del = 1'b0;
  endfunction

  function automatic void flag_error(err_e code);
    if (pr_err == ERR_NONE) pr_err = code;
    pr_phase = PH_ABSORB;
  endfunction

  function automatic logic [LIM_W-1:0] limit_of(logic [1:0] f);
    case (f)
      TAG_RID: return lim.max_request_id_len;
      TAG_KEY: return lim.max_key_len;
      default: return lim.max_value_len;
    endcase
  endfunction

  function automatic logic [1:0] field_of(phase_e p);
    return 2'((p - PH_LEN0) >> 1);
  endfunction

  function automatic err_e close_field(logic [1:0] f);
    if (f < TAG_VALUE) begin
      pr_phase = phase_e'(PH_LEN0 + 2 * (f + 1));
      pr_len = '0;
      pr_cnt = 0;
      return ERR_LEN_CUT;
    end
    pr_phase = PH_TAIL;
    return ERR_NONE;
  endfunction

  function automatic out_word_t parse_byte(in_word_t w);
    out_word_t  r;
    err_e       end_code;
    logic [1:0] f;
    logic [7:0] b;
    b = w.in_byte;
    r = '0;
    end_code = ERR_NONE;
    case (pr_phase)
      PH_VERSION: begin
        end_code = ERR_SHORT;
        if (!w.end_of_message) begin
          if (b != VERSION_BYTE) flag_error(ERR_VERSION);
          else pr_phase = PH_OP;
        end
      end
      PH_OP: begin
        if (b == OP_PUT || b == OP_DELETE) begin
          pr_del = (b == OP_DELETE);
          pr_phase = PH_LEN0;
          pr_len = '0;
          pr_cnt = 0;
          end_code = ERR_LEN_CUT;
        end else begin
          flag_error(ERR_OP);
        end
      end
      PH_LEN0, PH_LEN1, PH_LEN2: begin
        f = field_of(pr_phase);
        if (pr_len[31:24] != 8'd0) pr_len = '1;
        else pr_len = {pr_len[23:0], b};
        if (pr_cnt + 1 < LEN_BYTES) begin
          pr_cnt++;
          end_code = ERR_LEN_CUT;
        end else if (pr_len > 32'(limit_of(f))) begin
          flag_error(err_e'(ERR_RID_LIM + f));
        end else if (pr_len == '0) begin
          end_code = close_field(f);
        end else begin
          pr_left = pr_len;
          pr_phase = phase_e'(pr_phase + 1);
          end_code = ERR_PAY_CUT;
        end
      end
      PH_PAY0, PH_PAY1, PH_PAY2: begin
        f = field_of(pr_phase);
        r.payload_valid = 1'b1;
        r.field_tag = f;
        r.out_byte = b;
        if (pr_left != '0) pr_left--;
        if (pr_left == '0) end_code = close_field(f);
        else end_code = ERR_PAY_CUT;
      end
      PH_TAIL: flag_error(ERR_TRAILING);
      default: pr_phase = PH_ABSORB;
    endcase
    r.message_done = w.end_of_message;
    r.is_delete = pr_del;
    if (w.end_of_message) begin
      r.error_code = (pr_err != ERR_NONE) ? pr_err : end_code;
      r.message_ok = (r.error_code == ERR_NONE);
      clear_parse();
    end
    return r;
  endfunction

  function automatic int next_gap(ref bit calm);
    if ($urandom_range(0, 31) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 18);
  endfunction

  task automatic send_word(in_word_t w, bit fixed, out_word_t fixed_res);
    int        gap;
    out_word_t res;
    gap = next_gap(tx_calm);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= w;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    res = parse_byte(w);
    parsed_q = {parsed_q, (fixed ? fixed_res : res)};
    items_sent++;
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (parsed_q.size() != 0) @(posedge clk);
  endtask

  task automatic set_limits(limits_t l);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_MAX_RID;
    cfg_data <= l.max_request_id_len;
    @(posedge clk);
    cfg_idx <= CFG_MAX_KEY;
    cfg_data <= l.max_key_len;
    @(posedge clk);
    cfg_idx <= CFG_MAX_VALUE;
    cfg_data <= l.max_value_len;
    @(posedge clk);
    cfg_idx <= CFG_SPARE;
    cfg_data <= CFG_DATA_W'($urandom);
    @(posedge clk);
    cfg_we <= 1'b0;
    lim = l;
  endtask

  function automatic logic [LIM_W-1:0] pick_limit();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return LIM_W'($urandom_range(1, 8));
      2: return '1;
      default: return LIM_W'($urandom);
    endcase
  endfunction

  function automatic void push_field(logic [1:0] f, bit over);
    int unsigned      cap;
    int unsigned      n;
    logic [31:0]      len;
    logic [LIM_W-1:0] lm;
    lm = limit_of(f);
    cap = (lm < 6) ? lm : 6;
    n = $urandom_range(0, cap);
    if (lm <= 12 && $urandom_range(0, 3) == 0) n = lm;
    len = n;
    if (over) begin
      if ($urandom_range(0, 1) == 0) len = 32'(lm) + 1;
      else len = {8'($urandom_range(1, 255)), 24'($urandom)};
    end
    for (int k = LEN_BYTES - 1; k >= 0; k--) cmd_bytes = {cmd_bytes, len[8*k +: 8]};
    if (!over) repeat (n) cmd_bytes = {cmd_bytes, 8'($urandom)};
  endfunction

  function automatic void build_cmd(cmd_kind_e kind);
    logic [7:0]  b;
    int unsigned keep;
    logic [1:0]  bad_f;
    cmd_bytes.delete();
    if (kind == CMD_NOISE) begin
      repeat ($urandom_range(1, 8)) cmd_bytes = {cmd_bytes, 8'($urandom)};
      return;
    end
    b = 8'($urandom);
    if (b == VERSION_BYTE) b = ~b;
    cmd_bytes = {cmd_bytes, (kind == CMD_BAD_VER ? b : VERSION_BYTE)};
    b = 8'($urandom);
    if (b == OP_PUT || b == OP_DELETE) b = b ^ 8'h80;
    if (kind != CMD_BAD_OP) b = ($urandom_range(0, 1) == 0) ? OP_PUT : OP_DELETE;
    cmd_bytes = {cmd_bytes, b};
    bad_f = 2'($urandom_range(0, 2));
    for (int f = 0; f <= TAG_VALUE; f++) push_field(2'(f), kind == CMD_OVER && 2'(f) == bad_f);
    if (kind == CMD_TRAIL) repeat ($urandom_range(1, 3)) cmd_bytes = {cmd_bytes, 8'($urandom)};
    if (kind == CMD_CUT) begin
      keep = $urandom_range(1, cmd_bytes.size() - 1);
      while (cmd_bytes.size() > keep) void'(cmd_bytes.pop_back());
    end
  endfunction

  function automatic cmd_kind_e pick_kind();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return CMD_GOOD;
    if (r < 67) return CMD_CUT;
    if (r < 75) return CMD_TRAIL;
    if (r < 81) return CMD_BAD_VER;
    if (r < 87) return CMD_BAD_OP;
    if (r < 94) return CMD_OVER;
    return CMD_NOISE;
  endfunction

  task automatic send_cmd(cmd_kind_e kind);
    in_word_t w;
    build_cmd(kind);
    foreach (cmd_bytes[i]) begin
      w.in_byte = cmd_bytes[i];
      w.end_of_message = (i == cmd_bytes.size() - 1);
      send_word(w, 1'b0, '0);
    end
  endtask

  function automatic out_word_t verdict(logic [7:0] ob, logic pv, logic [1:0] tag, logic del,
                                        err_e code);
    out_word_t r;
    r.out_byte = ob;
    r.payload_valid = pv;
    r.field_tag = tag;
    r.message_done = 1'b1;
    r.message_ok = (code == ERR_NONE);
    r.is_delete = del;
    r.error_code = code;
    return r;
  endfunction

  function automatic void row(logic [7:0] b, logic eom);
    dir_row_t r;
    r.w.in_byte = b;
    r.w.end_of_message = eom;
    r.fixed = 1'b0;
    r.res = '0;
    dir_rows = {dir_rows, r};
  endfunction

  function automatic void row_end(logic [7:0] b, out_word_t res);
    dir_row_t r;
    r.w.in_byte = b;
    r.w.end_of_message = 1'b1;
    r.fixed = 1'b1;
    r.res = res;
    dir_rows = {dir_rows, r};
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t mismatch %s: expected %0h, actual %0h", $time, name, want, got);
      err_count++;
    end
  endtask

  initial begin : rx_side
    int        gap;
    out_word_t got;
    out_word_t want;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = next_gap(rx_calm);
      if (rx_hold > 0) begin
        gap = rx_hold;
        rx_hold = 0;
      end
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      got = out_ch.data;
      if (parsed_q.size() == 0) begin
        $display("%0t unexpected word: expected none, actual %h", $time, got);
        err_count++;
      end else begin
        want = parsed_q.pop_front();
        check_field("out_byte", want.out_byte, got.out_byte);
        check_field("payload_valid", want.payload_valid, got.payload_valid);
        check_field("field_tag", want.field_tag, got.field_tag);
        check_field("message_done", want.message_done, got.message_done);
        check_field("message_ok", want.message_ok, got.message_ok);
        check_field("is_delete", want.is_delete, got.is_delete);
        check_field("error_code", want.error_code, got.error_code);
      end
    end
  end

  initial begin : stimulus
    limits_t l;
    int      phase_start;
    bit      held;
    rst_n <= 1'b0;
    in_ch.valid <= 1'b0;
    in_ch.data <= '0;
    cfg_we <= 1'b0;
    cfg_idx <= '0;
    cfg_data <= '0;
    lim = '{RST_MAX_RID, RST_MAX_KEY, RST_MAX_VALUE};
    clear_parse();
    held = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset limits
    row_end(8'h00, verdict(8'h00, 1'b0, TAG_RID, 1'b0, ERR_SHORT));
    row(8'hFF, 1'b0);
    row_end(VERSION_BYTE, verdict(8'h00, 1'b0, TAG_RID, 1'b0, ERR_VERSION));
    row(VERSION_BYTE, 1'b0);
    row_end(8'h00, verdict(8'h00, 1'b0, TAG_RID, 1'b0, ERR_OP));
    row(VERSION_BYTE, 1'b0);
    row_end(OP_DELETE, verdict(8'h00, 1'b0, TAG_RID, 1'b1, ERR_LEN_CUT));
    row(VERSION_BYTE, 1'b0);
    row(OP_PUT, 1'b0);
    row(8'h00, 1'b0);
    row(8'h00, 1'b0);
    row(8'h00, 1'b0);
    row(8'h01, 1'b0);
    row_end(8'h80, verdict(8'h80, 1'b1, TAG_RID, 1'b0, ERR_LEN_CUT));
    row(VERSION_BYTE, 1'b0);
    row(OP_DELETE, 1'b0);
    row(8'h00, 1'b0);
    row(8'h10, 1'b0);
    row(8'h00, 1'b0);
    row_end(8'h00, verdict(8'h00, 1'b0, TAG_RID, 1'b1, ERR_RID_LIM));
    row(VERSION_BYTE, 1'b0);
    row(OP_PUT, 1'b0);
    row_end(8'hFF, verdict(8'h00, 1'b0, TAG_RID, 1'b0, ERR_LEN_CUT));
    foreach (dir_rows[i]) send_word(dir_rows[i].w, dir_rows[i].fixed, dir_rows[i].res);
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: l = '{LIM_W'($urandom_range(0, 8)), LIM_W'($urandom_range(0, 8)),
                 LIM_W'($urandom_range(0, 8))};
        1: l = '{'0, '0, '0};
        2: l = '{'1, '1, '1};
        3: l = '{RST_MAX_RID, RST_MAX_KEY, RST_MAX_VALUE};
        default: l = '{pick_limit(), pick_limit(), pick_limit()};
      endcase
      set_limits(l);
      phase_start = items_sent;
      while (items_sent - phase_start < PHASE_WORDS) begin
        if (p == 2 && !held && items_sent - phase_start >= 20) begin
          rx_hold = HOLD_CYCLES;
          held = 1'b1;
        end
        send_cmd(pick_kind());
      end
      drain_results();
    end

    repeat (4) @(posedge clk);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
